// File: rtl/recent_match_weighted_ranker_core_defines.svh
// Assertion macros shared by the checker of the recent match ranker.
`ifndef RECENT_MATCH_WEIGHTED_RANKER_CORE_DEFINES_SVH
`define RECENT_MATCH_WEIGHTED_RANKER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define RMWR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define RMWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/rmwr_pkg.sv
// Shared constants, opcodes and the recency weight table of the ranker.
`timescale 1ns / 1ps
package rmwr_pkg;
    localparam int RING_SLOTS_DEF   = 256;
    localparam int PAGE_SLOTS_DEF   = 128;
    localparam int SCAN_LIMIT_DEF   = 128;
    localparam int MAX_DISTINCT_DEF = 16;

    localparam int ID_W   = 8;
    localparam int SUM_W  = 10;
    localparam int RANK_W = 4;
    localparam int CAND_N = 16;
    localparam int CAND_W = 4;
    localparam int CNT_W  = 5;
    localparam int WT_W   = 7;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    function automatic logic [WT_W-1:0] recency_weight(input logic [CAND_W-1:0] idx);
        logic [WT_W-1:0] w;
        case (idx)
            4'd0:    w = 7'd100;
            4'd1:    w = 7'd76;
            4'd2:    w = 7'd57;
            4'd3:    w = 7'd42;
            4'd4:    w = 7'd32;
            4'd5:    w = 7'd25;
            4'd6:    w = 7'd20;
            4'd7:    w = 7'd16;
            4'd8:    w = 7'd13;
            4'd9:    w = 7'd10;
            4'd10:   w = 7'd8;
            4'd11:   w = 7'd6;
            4'd12:   w = 7'd5;
            4'd13:   w = 7'd4;
            4'd14:   w = 7'd3;
            default: w = 7'd2;
        endcase
        return w;
    endfunction
endpackage

// File: rtl/recent_match_weighted_ranker_core.sv
// Top level of the recent match ranker: history ring, walk and ranking sort.
`timescale 1ns / 1ps
// The block keeps a ring log of recently matched finger ids, grouped in pages,
// with a valid mark per slot. An append item writes one slot; if it lands on
// a slot that is still valid, the whole page holding that slot is dropped
// first. A clear item drops page 0 and produces nothing. A query item walks
// back from the newest slot, for each slot first reading the id memory, then
// folding the id into the 16 candidate lanes, over at most SCAN_LIMIT slots,
// then ranks the candidates with a selection sort that reads one lane per
// cycle, each result waiting in the output register until it is taken. A
// query with no valid slot returns one item with none_found set. The input is
// stalled for the whole query; results come out heaviest first, the last one
// marked.
module recent_match_weighted_ranker_core #(
    parameter int RING_SLOTS   = rmwr_pkg::RING_SLOTS_DEF,
    parameter int PAGE_SLOTS   = rmwr_pkg::PAGE_SLOTS_DEF,
    parameter int SCAN_LIMIT   = rmwr_pkg::SCAN_LIMIT_DEF,
    parameter int MAX_DISTINCT = rmwr_pkg::MAX_DISTINCT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [rmwr_pkg::ID_W-1:0]     i_finger_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rmwr_pkg::ID_W-1:0]     o_ranked_id,
    output logic [rmwr_pkg::SUM_W-1:0]    o_weight_sum,
    output logic [rmwr_pkg::RANK_W-1:0]   o_rank,
    output logic                          o_none_found,
    output logic                          o_last
);
    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int PW     = $clog2(RING_SLOTS + PAGE_SLOTS + 1);
    localparam int OFF_W  = $clog2(PAGE_SLOTS + 1);
    localparam int IW     = $clog2(SCAN_LIMIT) + 1;
    localparam int ID_W   = rmwr_pkg::ID_W;
    localparam int SUM_W  = rmwr_pkg::SUM_W;
    localparam int CNT_W  = rmwr_pkg::CNT_W;
    localparam int CAND_W = rmwr_pkg::CAND_W;
    localparam int CAND_N = rmwr_pkg::CAND_N;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_SEL  = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_NONE = 7'b1000000
    } t_state;

    t_state r_state;

    // History ring: ids in a synchronous memory, valid marks in flip-flops.
    logic [ID_W-1:0]       r_hist_ids [RING_SLOTS];
    logic [ID_W-1:0]       r_rd_data;
    logic [RING_SLOTS-1:0] r_valid;
    logic [RING_SLOTS-1:0] n_valid;

    // The write pointer carries the base and offset of its page along.
    logic [SLOT_W-1:0] r_wp;
    logic [PW-1:0]     r_pg_base;
    logic [OFF_W-1:0]  r_pg_off;
    logic [PW-1:0]     pg_hi;

    // Walk state.
    logic [SLOT_W-1:0] r_slot;
    logic [IW-1:0]     r_i;
    logic [CNT_W-1:0]  r_n;

    // Candidate lanes.
    logic [ID_W-1:0]  r_cid  [CAND_N];
    logic [SUM_W-1:0] r_csum [CAND_N];

    // Sort state.
    logic [CAND_W-1:0] r_si;
    logic [CNT_W-1:0]  r_j;
    logic [CAND_W-1:0] r_at;
    logic [SUM_W-1:0]  r_best;
    logic [ID_W-1:0]   r_best_id;
    logic [SUM_W-1:0]  r_sav_sum;
    logic [ID_W-1:0]   r_sav_id;

    // Output register.
    logic                        r_ov;
    logic [ID_W-1:0]             r_o_id;
    logic [SUM_W-1:0]            r_o_sum;
    logic [rmwr_pkg::RANK_W-1:0] r_o_rank;
    logic                        r_o_none;
    logic                        r_o_last;

    logic              in_acc;
    logic              do_append;
    logic              do_clear;
    logic              out_free;
    logic [CAND_N-1:0] hit;
    logic              any_hit;
    logic [SUM_W-1:0]  wt;
    logic [CNT_W-1:0]  n_plus;
    logic              si_last;
    logic [CNT_W-1:0]  j_next;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign do_append = in_acc && (i_opcode == rmwr_pkg::OP_APPEND);
    assign do_clear  = in_acc && (i_opcode == rmwr_pkg::OP_CLEAR);
    assign out_free  = !r_ov || !i_out_stall;
    assign pg_hi     = r_pg_base + PW'(PAGE_SLOTS);
    assign n_plus    = r_n + CNT_W'(1);
    assign si_last   = (CNT_W'(r_si) + CNT_W'(1)) == r_n;
    assign j_next    = r_j + CNT_W'(1);

    assign wt = (r_i < IW'(16)) ? SUM_W'(rmwr_pkg::recency_weight(r_i[CAND_W-1:0]))
                                : SUM_W'(1);

    always_comb begin
        for (int j = 0; j < CAND_N; j++) begin
            hit[j] = (CNT_W'(j) < r_n) && (r_cid[j] == r_rd_data);
        end
        any_hit = |hit;
    end

    // Valid marks: page drop on overwrite or clear, then the new mark.
    always_comb begin
        n_valid = r_valid;
        for (int k = 0; k < RING_SLOTS; k++) begin
            if (do_append && r_valid[r_wp] && (PW'(k) >= r_pg_base) && (PW'(k) < pg_hi)) begin
                n_valid[k] = 1'b0;
            end
            if (do_clear && (k < PAGE_SLOTS)) begin
                n_valid[k] = 1'b0;
            end
        end
        if (do_append) begin
            n_valid[r_wp] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_hist_ids[r_wp] <= i_finger_id;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_hist_ids[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_wp      <= '0;
            r_pg_base <= '0;
            r_pg_off  <= '0;
            r_ov      <= 1'b0;
            r_n       <= '0;
            r_i       <= '0;
            r_si      <= '0;
            r_j       <= '0;
        end else begin
            r_valid <= n_valid;
            // A taken result empties the register unless a new one is loaded.
            if (r_ov && !i_out_stall && (r_state != S_EMIT) && (r_state != S_NONE)) begin
                r_ov <= 1'b0;
            end
            if (do_append) begin
                if (r_wp == SLOT_W'(RING_SLOTS - 1)) begin
                    r_wp      <= '0;
                    r_pg_base <= '0;
                    r_pg_off  <= '0;
                end else begin
                    r_wp <= r_wp + SLOT_W'(1);
                    if (r_pg_off == OFF_W'(PAGE_SLOTS - 1)) begin
                        r_pg_off  <= '0;
                        r_pg_base <= pg_hi;
                    end else begin
                        r_pg_off <= r_pg_off + OFF_W'(1);
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_opcode == rmwr_pkg::OP_QUERY)) begin
                        r_i     <= '0;
                        r_n     <= '0;
                        r_slot  <= (r_wp == '0) ? SLOT_W'(RING_SLOTS - 1) : r_wp - SLOT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (!r_valid[r_slot]) begin
                        r_si    <= '0;
                        r_state <= (r_n == '0) ? S_NONE : S_SEL;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    for (int j = 0; j < CAND_N; j++) begin
                        if (hit[j]) begin
                            r_csum[j] <= r_csum[j] + wt;
                        end
                    end
                    if (!any_hit) begin
                        r_cid[r_n[CAND_W-1:0]]  <= r_rd_data;
                        r_csum[r_n[CAND_W-1:0]] <= wt;
                        r_n <= n_plus;
                    end
                    if ((!any_hit && (n_plus >= CNT_W'(MAX_DISTINCT)))
                        || (r_i == IW'(SCAN_LIMIT - 1))) begin
                        r_si    <= '0;
                        r_state <= S_SEL;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_slot  <= (r_slot == '0) ? SLOT_W'(RING_SLOTS - 1)
                                                  : r_slot - SLOT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_SEL: begin
                    r_best    <= r_csum[r_si];
                    r_best_id <= r_cid[r_si];
                    r_sav_sum <= r_csum[r_si];
                    r_sav_id  <= r_cid[r_si];
                    r_at      <= r_si;
                    r_j       <= CNT_W'(r_si) + CNT_W'(1);
                    r_state   <= si_last ? S_EMIT : S_SCAN;
                end
                S_SCAN: begin
                    // Strictly greater keeps the earliest lane among equal sums.
                    if (r_csum[r_j[CAND_W-1:0]] > r_best) begin
                        r_best    <= r_csum[r_j[CAND_W-1:0]];
                        r_best_id <= r_cid[r_j[CAND_W-1:0]];
                        r_at      <= r_j[CAND_W-1:0];
                    end
                    if (j_next == r_n) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_j <= j_next;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_id   <= r_best_id;
                        r_o_sum  <= r_best;
                        r_o_rank <= r_si;
                        r_o_none <= 1'b0;
                        r_o_last <= si_last;
                        if (r_at != r_si) begin
                            r_csum[r_at] <= r_sav_sum;
                            r_cid[r_at]  <= r_sav_id;
                        end
                        r_csum[r_si] <= r_best;
                        r_cid[r_si]  <= r_best_id;
                        if (si_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_si    <= r_si + CAND_W'(1);
                            r_state <= S_SEL;
                        end
                    end
                end
                S_NONE: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_id   <= '0;
                        r_o_sum  <= '0;
                        r_o_rank <= '0;
                        r_o_none <= 1'b1;
                        r_o_last <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_ranked_id  = r_o_id;
    assign o_weight_sum = r_o_sum;
    assign o_rank       = r_o_rank;
    assign o_none_found = r_o_none;
    assign o_last       = r_o_last;
endmodule

// File: rtl/rmwr_checker.sv
// Port-level checker for the recent match ranker and its bind.
`timescale 1ns / 1ps
`include "recent_match_weighted_ranker_core_defines.svh"
module rmwr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [1:0]                  i_opcode,
    input logic [rmwr_pkg::ID_W-1:0]   i_finger_id,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rmwr_pkg::ID_W-1:0]   o_ranked_id,
    input logic [rmwr_pkg::SUM_W-1:0]  o_weight_sum,
    input logic [rmwr_pkg::RANK_W-1:0] o_rank,
    input logic                        o_none_found,
    input logic                        o_last
);
    // A stalled result keeps its payload.
    `RMWR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_ranked_id) && $stable(o_weight_sum) && $stable(o_rank))
    // An empty query reports zeros and closes the query.
    `RMWR_ASSERT_SAME(a_none_zero, i_clk, i_rst_n, o_out_valid && o_none_found,
        o_last && (o_ranked_id == '0) && (o_weight_sum == '0) && (o_rank == '0))
    // While more results of a query are due, no new item is taken.
    `RMWR_ASSERT_SAME(a_busy_mid, i_clk, i_rst_n, o_out_valid && !o_last, o_in_stall)
endmodule

bind recent_match_weighted_ranker_core rmwr_checker u_rmwr_checker (.*);
